FILE: design/vra_pkg.sv
// ---------------------------------------------------------------------------
// vra_pkg: shared definitions of the address range allocator
// Field widths, default sizes, operation and status codes, and the command
// that steers the row of range cells.
// ---------------------------------------------------------------------------
package vra_pkg;

    localparam int DEF_MAX_RANGES = 64;
    localparam int DEF_PAGE_BITS  = 12;
    localparam int DEF_ADDR_BITS  = 48;

    localparam int OP_W       = 2;
    localparam int BASE_W     = 48;
    localparam int SIZE_W     = 49;
    localparam int BOUND_W    = 49;
    localparam int HANDLE_W   = 32;
    localparam int OFFSET_W   = 48;
    localparam int STATUS_W   = 3;
    localparam int ADDRESS_W  = 48;
    localparam int TOTAL_W    = 49;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 49;

    localparam logic [CFG_DATA_W-1:0] GUARD_RESET = 49'h0_0000_0001_0000;
    localparam logic [CFG_DATA_W-1:0] LIMIT_RESET = 49'h1_0000_0000_0000;

    localparam logic [CFG_IDX_W-1:0] CFG_GUARD_BASE  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPACE_LIMIT = 8'd1;

    localparam logic [OP_W-1:0] OP_RESERVE = 2'd0;
    localparam logic [OP_W-1:0] OP_MAP     = 2'd1;
    localparam logic [OP_W-1:0] OP_FREE    = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_MEMORY = 3'd2;
    localparam logic [STATUS_W-1:0] ST_CONFLICT  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

    typedef enum logic [1:0] {
        CM_HOLD   = 2'd0,
        CM_ROTATE = 2'd1,
        CM_INSERT = 2'd2,
        CM_REMOVE = 2'd3
    } chain_mode_t;

endpackage

FILE: design/vra_cell.sv
// ---------------------------------------------------------------------------
// vra_cell: one slot of the sorted range table
// Holds one range word and takes its neighbor's word when the row rotates,
// opens a slot for an insert or closes one after a removal.
// ---------------------------------------------------------------------------
module vra_cell #(
    parameter int EW  = 8,
    parameter int IW  = 6,
    parameter int IDX = 0
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  vra_pkg::chain_mode_t  mode,
    input  logic [IW-1:0]         pos,
    input  logic [EW-1:0]         new_data,
    input  logic                  prev_valid,
    input  logic [EW-1:0]         prev_data,
    input  logic                  next_valid,
    input  logic [EW-1:0]         next_data,
    output logic                  valid,
    output logic [EW-1:0]         data
);
    import vra_pkg::*;

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic          valid_reg, valid_next;
    logic [EW-1:0] data_reg, data_next;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        case (mode)
            CM_ROTATE: begin
                valid_next = next_valid;
                data_next  = next_data;
            end
            CM_INSERT: begin
                if (MY_IDX == pos) begin
                    valid_next = 1'b1;
                    data_next  = new_data;
                end else if (MY_IDX > pos) begin
                    valid_next = prev_valid;
                    data_next  = prev_data;
                end
            end
            CM_REMOVE: begin
                if (MY_IDX >= pos) begin
                    valid_next = next_valid;
                    data_next  = next_data;
                end
            end
            default: begin
                valid_next = valid_reg;
                data_next  = data_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

FILE: design/vra_ctrl.sv
// ---------------------------------------------------------------------------
// vra_ctrl: request sequencer of the address range allocator
// Prepares bounds, scans the rotating range row one word per cycle for
// overlaps, gaps and matches, then edits the row and updates the totals.
// ---------------------------------------------------------------------------
module vra_ctrl #(
    parameter int MAX_RANGES = 64,
    parameter int PAGE_BITS  = 12,
    parameter int ADDR_BITS  = 48,
    parameter int EW         = 8,
    parameter int IW         = 6
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [vra_pkg::OP_W-1:0]          s_op,
    input  logic [vra_pkg::BASE_W-1:0]        s_base_address,
    input  logic [vra_pkg::SIZE_W-1:0]        s_size_bytes,
    input  logic [vra_pkg::BOUND_W-1:0]       s_min_address,
    input  logic [vra_pkg::BOUND_W-1:0]       s_max_address,
    input  logic [vra_pkg::HANDLE_W-1:0]      s_allocation_handle,
    input  logic [vra_pkg::OFFSET_W-1:0]      s_allocation_offset,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [vra_pkg::STATUS_W-1:0]      m_status,
    output logic [vra_pkg::ADDRESS_W-1:0]     m_address,
    output logic [vra_pkg::TOTAL_W-1:0]       m_total_reserved,
    output logic [vra_pkg::TOTAL_W-1:0]       m_total_mapped,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [vra_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [vra_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              head_valid,
    input  logic [EW-1:0]                     head_data,
    output vra_pkg::chain_mode_t              chain_mode,
    output logic [IW-1:0]                     chain_pos,
    output logic [EW-1:0]                     chain_new
);
    import vra_pkg::*;

    localparam int PB     = PAGE_BITS;
    localparam int AB     = ADDR_BITS;
    localparam int SPW    = AB - PB;
    localparam int SZW    = SPW + 1;
    localparam int CW     = ((AB > SIZE_W) ? AB : SIZE_W) + 2;
    localparam int UW     = $clog2(MAX_RANGES + 1);
    localparam int SZ_LSB = 0;
    localparam int SP_LSB = SZW;
    localparam int OF_LSB = SP_LSB + SPW;
    localparam int TG_LSB = OF_LSB + OFFSET_W;
    localparam int MP_BIT = TG_LSB + HANDLE_W;

    localparam logic [CW-1:0] PG_SIZE   = CW'(1) << PB;
    localparam logic [CW-1:0] PG_MASK   = PG_SIZE - CW'(1);
    localparam logic [CW-1:0] SPACE_END = CW'(1) << AB;
    localparam logic [IW-1:0] LAST_IDX  = IW'(MAX_RANGES - 1);
    localparam logic [UW-1:0] FULL_CNT  = UW'(MAX_RANGES);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_PRE1 = 9'b000000010,
        S_PRE2 = 9'b000000100,
        S_PRE3 = 9'b000001000,
        S_PRE4 = 9'b000010000,
        S_SCAN = 9'b000100000,
        S_FIN  = 9'b001000000,
        S_EDIT = 9'b010000000,
        S_DONE = 9'b100000000
    } state_t;

    function automatic logic [CW-1:0] align_up(input logic [CW-1:0] v);
        align_up = (v + PG_MASK) & ~PG_MASK;
    endfunction

    state_t                 state_reg, state_next;
    logic [OP_W-1:0]        op_reg, op_next;
    logic [BASE_W-1:0]      base_reg, base_next;
    logic [SIZE_W-1:0]      size_reg, size_next;
    logic [BOUND_W-1:0]     mn_reg, mn_next;
    logic [BOUND_W-1:0]     mx_reg, mx_next;
    logic [HANDLE_W-1:0]    tag_reg, tag_next;
    logic [OFFSET_W-1:0]    off_reg, off_next;
    logic [CFG_DATA_W-1:0]  guard_reg, guard_next;
    logic [CFG_DATA_W-1:0]  limit_reg, limit_next;
    logic [CW-1:0]          fl_reg, fl_next;
    logic [CW-1:0]          sal_reg, sal_next;
    logic [CW-1:0]          loc_reg, loc_next;
    logic [CW-1:0]          loc_al_reg, loc_al_next;
    logic [CW-1:0]          hi_reg, hi_next;
    logic [CW-1:0]          a_reg, a_next;
    logic [CW-1:0]          aend_reg, aend_next;
    logic [CW-1:0]          prev_end_reg, prev_end_next;
    logic                   found_reg, found_next;
    logic [IW-1:0]          idx_reg, idx_next;
    logic [IW-1:0]          pos_reg, pos_next;
    logic [UW-1:0]          hit_cnt_reg, hit_cnt_next;
    logic [UW-1:0]          used_reg, used_next;
    logic [TOTAL_W-1:0]     sub_res_reg, sub_res_next;
    logic [TOTAL_W-1:0]     sub_map_reg, sub_map_next;
    logic [TOTAL_W-1:0]     res_tot_reg, res_tot_next;
    logic [TOTAL_W-1:0]     map_tot_reg, map_tot_next;
    logic [STATUS_W-1:0]    status_reg, status_next;
    logic                   m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]    m_status_reg, m_status_next;
    logic [ADDRESS_W-1:0]   m_address_reg, m_address_next;
    logic [TOTAL_W-1:0]     m_res_reg, m_res_next;
    logic [TOTAL_W-1:0]     m_map_reg, m_map_next;

    logic                   is_map, is_place, is_free, is_search, size_zero;
    logic [CW-1:0]          h_st, h_en, c_cur, c_end, g_al, loc_w, hi_w, a0;
    logic                   fit, span_hit, exact_hit, hit, pos_inc;

    assign is_map    = (op_reg == OP_MAP);
    assign is_place  = (op_reg == OP_RESERVE) || (op_reg == OP_MAP);
    assign is_free   = (op_reg == OP_FREE);
    assign is_search = (base_reg == '0);
    assign size_zero = (size_reg == '0);

    assign h_st  = CW'(head_data[SP_LSB +: SPW]) << PB;
    assign h_en  = h_st + (CW'(head_data[SZ_LSB +: SZW]) << PB);
    assign c_cur = (a_reg > prev_end_reg) ? a_reg : prev_end_reg;
    assign c_end = c_cur + sal_reg;

    assign fit = head_valid && !found_reg && (h_en > c_cur)
                 && (c_end <= h_st) && (c_end <= hi_reg);
    assign span_hit  = head_valid && (h_st < aend_reg) && (a_reg < h_en);
    assign exact_hit = head_valid && (h_st == a_reg);
    assign hit       = (is_free && size_zero) ? exact_hit : span_hit;
    assign pos_inc   = is_search ? (head_valid && !found_reg && !fit)
                                 : (head_valid && (h_st <= a_reg));

    assign g_al  = align_up(CW'(guard_reg));
    assign loc_w = (is_map && mn_reg != '0) ? CW'(mn_reg) : fl_reg;
    assign hi_w  = (is_map && mx_reg != '0) ? CW'(mx_reg) : CW'(limit_reg);
    assign a0    = CW'(base_reg) & ~PG_MASK;

    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        base_next      = base_reg;
        size_next      = size_reg;
        mn_next        = mn_reg;
        mx_next        = mx_reg;
        tag_next       = tag_reg;
        off_next       = off_reg;
        guard_next     = guard_reg;
        limit_next     = limit_reg;
        fl_next        = fl_reg;
        sal_next       = sal_reg;
        loc_next       = loc_reg;
        loc_al_next    = loc_al_reg;
        hi_next        = hi_reg;
        a_next         = a_reg;
        aend_next      = aend_reg;
        prev_end_next  = prev_end_reg;
        found_next     = found_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        hit_cnt_next   = hit_cnt_reg;
        used_next      = used_reg;
        sub_res_next   = sub_res_reg;
        sub_map_next   = sub_map_reg;
        res_tot_next   = res_tot_reg;
        map_tot_next   = map_tot_reg;
        status_next    = status_reg;
        m_valid_next   = m_valid_reg;
        m_status_next  = m_status_reg;
        m_address_next = m_address_reg;
        m_res_next     = m_res_reg;
        m_map_next     = m_map_reg;
        chain_mode     = CM_HOLD;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_valid) begin
            if (cfg_index == CFG_GUARD_BASE) begin
                guard_next = cfg_data;
            end else if (cfg_index == CFG_SPACE_LIMIT) begin
                limit_next = cfg_data;
            end
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next    = s_op;
                    base_next  = s_base_address;
                    size_next  = s_size_bytes;
                    mn_next    = s_min_address;
                    mx_next    = s_max_address;
                    tag_next   = s_allocation_handle;
                    off_next   = s_allocation_offset;
                    state_next = S_PRE1;
                end
            end
            S_PRE1: begin
                fl_next     = (g_al < PG_SIZE) ? PG_SIZE : g_al;
                sal_next    = align_up(CW'(size_reg));
                status_next = ST_OK;
                state_next  = S_PRE2;
                if (!is_place && !is_free) begin
                    status_next = ST_INVALID;
                    state_next  = S_DONE;
                end else if (is_place && (size_zero || (is_map && tag_reg == '0))) begin
                    status_next = ST_INVALID;
                    state_next  = S_DONE;
                end else if (is_place && used_reg == FULL_CNT) begin
                    status_next = ST_NO_MEMORY;
                    state_next  = S_DONE;
                end else if (is_free && is_search) begin
                    status_next = ST_INVALID;
                    state_next  = S_DONE;
                end
            end
            S_PRE2: begin
                loc_next    = loc_w;
                loc_al_next = align_up(loc_w);
                hi_next     = (hi_w > SPACE_END) ? SPACE_END : hi_w;
                state_next  = S_PRE3;
            end
            S_PRE3: begin
                if (is_free) begin
                    a_next = CW'(base_reg);
                end else if (!is_search) begin
                    a_next = (a0 < loc_reg) ? loc_al_reg : a0;
                end else begin
                    a_next = (loc_al_reg < fl_reg) ? fl_reg : loc_al_reg;
                end
                state_next = S_PRE4;
            end
            S_PRE4: begin
                aend_next     = a_reg + sal_reg;
                prev_end_next = '0;
                found_next    = 1'b0;
                idx_next      = '0;
                pos_next      = '0;
                hit_cnt_next  = '0;
                sub_res_next  = '0;
                sub_map_next  = '0;
                state_next    = S_SCAN;
                if (is_place && !is_search && (a_reg + sal_reg > SPACE_END)) begin
                    status_next = ST_INVALID;
                    state_next  = S_DONE;
                end
            end
            S_SCAN: begin
                chain_mode = CM_ROTATE;
                if (is_place) begin
                    if (fit && is_search) begin
                        found_next = 1'b1;
                        a_next     = c_cur;
                    end
                    if (pos_inc) begin
                        pos_next = pos_reg + IW'(1);
                    end
                end
                if (hit) begin
                    hit_cnt_next = hit_cnt_reg + UW'(1);
                    if (is_free) begin
                        if (hit_cnt_reg == '0) begin
                            pos_next = idx_reg;
                        end
                        if (head_data[MP_BIT]) begin
                            sub_map_next = sub_map_reg + TOTAL_W'(h_en - h_st);
                        end else begin
                            sub_res_next = sub_res_reg + TOTAL_W'(h_en - h_st);
                        end
                    end
                end
                if (head_valid) begin
                    prev_end_next = h_en;
                end
                idx_next = idx_reg + IW'(1);
                if (idx_reg == LAST_IDX) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                state_next = S_EDIT;
                if (is_place) begin
                    if (!is_search && hit_cnt_reg != '0) begin
                        status_next = ST_CONFLICT;
                        state_next  = S_DONE;
                    end else if (is_search && !found_reg && !(c_end <= hi_reg)) begin
                        status_next = ST_NO_MEMORY;
                        state_next  = S_DONE;
                    end else begin
                        if (is_search && !found_reg) begin
                            a_next = c_cur;
                        end
                        if (is_map) begin
                            map_tot_next = map_tot_reg + sal_reg[TOTAL_W-1:0];
                        end else begin
                            res_tot_next = res_tot_reg + sal_reg[TOTAL_W-1:0];
                        end
                    end
                end else begin
                    if (hit_cnt_reg == '0) begin
                        status_next = ST_NOT_FOUND;
                        state_next  = S_DONE;
                    end else begin
                        res_tot_next = res_tot_reg - sub_res_reg;
                        map_tot_next = map_tot_reg - sub_map_reg;
                    end
                end
            end
            S_EDIT: begin
                if (is_place) begin
                    chain_mode = CM_INSERT;
                    used_next  = used_reg + UW'(1);
                    state_next = S_DONE;
                end else begin
                    chain_mode   = CM_REMOVE;
                    used_next    = used_reg - UW'(1);
                    hit_cnt_next = hit_cnt_reg - UW'(1);
                    if (hit_cnt_reg == UW'(1)) begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_status_next  = status_reg;
                    m_address_next = (status_reg == ST_OK && is_place)
                                     ? a_reg[ADDRESS_W-1:0] : '0;
                    m_res_next     = res_tot_reg;
                    m_map_next     = map_tot_reg;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            used_reg    <= '0;
            res_tot_reg <= '0;
            map_tot_reg <= '0;
            guard_reg   <= GUARD_RESET;
            limit_reg   <= LIMIT_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            res_tot_reg <= res_tot_next;
            map_tot_reg <= map_tot_next;
            guard_reg   <= guard_next;
            limit_reg   <= limit_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        base_reg      <= base_next;
        size_reg      <= size_next;
        mn_reg        <= mn_next;
        mx_reg        <= mx_next;
        tag_reg       <= tag_next;
        off_reg       <= off_next;
        fl_reg        <= fl_next;
        sal_reg       <= sal_next;
        loc_reg       <= loc_next;
        loc_al_reg    <= loc_al_next;
        hi_reg        <= hi_next;
        a_reg         <= a_next;
        aend_reg      <= aend_next;
        prev_end_reg  <= prev_end_next;
        found_reg     <= found_next;
        idx_reg       <= idx_next;
        pos_reg       <= pos_next;
        hit_cnt_reg   <= hit_cnt_next;
        sub_res_reg   <= sub_res_next;
        sub_map_reg   <= sub_map_next;
        status_reg    <= status_next;
        m_status_reg  <= m_status_next;
        m_address_reg <= m_address_next;
        m_res_reg     <= m_res_next;
        m_map_reg     <= m_map_next;
    end

    assign s_ready          = (state_reg == S_IDLE);
    assign cfg_ready        = 1'b1;
    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_address        = m_address_reg;
    assign m_total_reserved = m_res_reg;
    assign m_total_mapped   = m_map_reg;

    assign chain_pos = pos_reg;
    assign chain_new = {is_map,
                        is_map ? tag_reg : {HANDLE_W{1'b0}},
                        is_map ? off_reg : {OFFSET_W{1'b0}},
                        a_reg[PB +: SPW],
                        sal_reg[PB +: SZW]};

endmodule

FILE: design/va_range_allocator.sv
// ---------------------------------------------------------------------------
// va_range_allocator: first-fit allocator of page-aligned address ranges
// Sorted range table held in a row of cells that rotates past the sequencer once for each
// request that passes the early checks, followed by an insert or a series of removals.
// ---------------------------------------------------------------------------
// A request that passes the early checks rotates the cell row once. A placed reserve
// or map then inserts its range; one refused after the rotation or before it leaves
// the row as it was. A free then removes each range that it hit, one after another.
// One request is in flight at a time; the next is taken while a result waits.
// Synchronous active-low reset empties the table, clears the totals and loads defaults.
module va_range_allocator #(
    parameter int MAX_RANGES = vra_pkg::DEF_MAX_RANGES,
    parameter int PAGE_BITS  = vra_pkg::DEF_PAGE_BITS,
    parameter int ADDR_BITS  = vra_pkg::DEF_ADDR_BITS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [vra_pkg::OP_W-1:0]          s_op,
    input  logic [vra_pkg::BASE_W-1:0]        s_base_address,
    input  logic [vra_pkg::SIZE_W-1:0]        s_size_bytes,
    input  logic [vra_pkg::BOUND_W-1:0]       s_min_address,
    input  logic [vra_pkg::BOUND_W-1:0]       s_max_address,
    input  logic [vra_pkg::HANDLE_W-1:0]      s_allocation_handle,
    input  logic [vra_pkg::OFFSET_W-1:0]      s_allocation_offset,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [vra_pkg::STATUS_W-1:0]      m_status,
    output logic [vra_pkg::ADDRESS_W-1:0]     m_address,
    output logic [vra_pkg::TOTAL_W-1:0]       m_total_reserved,
    output logic [vra_pkg::TOTAL_W-1:0]       m_total_mapped,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [vra_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [vra_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import vra_pkg::*;

    localparam int SPW = ADDR_BITS - PAGE_BITS;
    localparam int SZW = SPW + 1;
    localparam int EW  = 1 + HANDLE_W + OFFSET_W + SPW + SZW;
    localparam int IW  = $clog2(MAX_RANGES);

    logic          cell_v [MAX_RANGES];
    logic [EW-1:0] cell_d [MAX_RANGES];
    chain_mode_t   chain_mode;
    logic [IW-1:0] chain_pos;
    logic [EW-1:0] chain_new;

    vra_ctrl #(
        .MAX_RANGES(MAX_RANGES),
        .PAGE_BITS (PAGE_BITS),
        .ADDR_BITS (ADDR_BITS),
        .EW        (EW),
        .IW        (IW)
    ) u_ctrl (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_op               (s_op),
        .s_base_address     (s_base_address),
        .s_size_bytes       (s_size_bytes),
        .s_min_address      (s_min_address),
        .s_max_address      (s_max_address),
        .s_allocation_handle(s_allocation_handle),
        .s_allocation_offset(s_allocation_offset),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_status           (m_status),
        .m_address          (m_address),
        .m_total_reserved   (m_total_reserved),
        .m_total_mapped     (m_total_mapped),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .head_valid         (cell_v[0]),
        .head_data          (cell_d[0]),
        .chain_mode         (chain_mode),
        .chain_pos          (chain_pos),
        .chain_new          (chain_new)
    );

    for (genvar i = 0; i < MAX_RANGES; i++) begin : g_cell
        logic          pv, nv;
        logic [EW-1:0] pd, nd;

        if (i == 0) begin : g_first
            assign pv = cell_v[0];
            assign pd = cell_d[0];
        end else begin : g_mid
            assign pv = cell_v[i-1];
            assign pd = cell_d[i-1];
        end

        if (i == MAX_RANGES - 1) begin : g_last
            assign nv = cell_v[0] && (chain_mode == CM_ROTATE);
            assign nd = cell_d[0];
        end else begin : g_inner
            assign nv = cell_v[i+1];
            assign nd = cell_d[i+1];
        end

        vra_cell #(
            .EW (EW),
            .IW (IW),
            .IDX(i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .mode      (chain_mode),
            .pos       (chain_pos),
            .new_data  (chain_new),
            .prev_valid(pv),
            .prev_data (pd),
            .next_valid(nv),
            .next_data (nd),
            .valid     (cell_v[i]),
            .data      (cell_d[i])
        );
    end

endmodule

FILE: sim/va_range_allocator_tb.sv
// ---------------------------------------------------------------------------
// va_range_allocator_tb: self-checking bench of the address range allocator
// Drives reserve, map and free requests, including edge and error cases, a
// full table and random traffic under several guard base and space limit
// settings. A behavioral copy of the sorted range table predicts each result
// word, which is compared field by field as it leaves the block.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module va_range_allocator_tb;
    import vra_pkg::*;

    localparam int          NRANGES    = DEF_MAX_RANGES;
    localparam bit [63:0]   PAGE       = 64'd4096;
    localparam bit [63:0]   SPACE_END  = 64'h1_0000_0000_0000;
    localparam int          QUIET      = 160;
    localparam int          IDLE_LIMIT = 4000;
    localparam int          HOLD_LEN   = 600;

    localparam logic [OP_W-1:0]      OP_UNKNOWN = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 8'd2;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [BASE_W-1:0]   base;
        logic [SIZE_W-1:0]   size;
        logic [BOUND_W-1:0]  min_addr;
        logic [BOUND_W-1:0]  max_addr;
        logic [HANDLE_W-1:0] handle;
        logic [OFFSET_W-1:0] offset;
    } request_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [ADDRESS_W-1:0] address;
        logic [TOTAL_W-1:0]   reserved;
        logic [TOTAL_W-1:0]   mapped;
    } outcome_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [OP_W-1:0] s_op = '0;
    logic [BASE_W-1:0] s_base_address = '0;
    logic [SIZE_W-1:0] s_size_bytes = '0;
    logic [BOUND_W-1:0] s_min_address = '0;
    logic [BOUND_W-1:0] s_max_address = '0;
    logic [HANDLE_W-1:0] s_allocation_handle = '0;
    logic [OFFSET_W-1:0] s_allocation_offset = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [STATUS_W-1:0] m_status;
    logic [ADDRESS_W-1:0] m_address;
    logic [TOTAL_W-1:0] m_total_reserved;
    logic [TOTAL_W-1:0] m_total_mapped;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    va_range_allocator dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_op(s_op),
        .s_base_address(s_base_address), .s_size_bytes(s_size_bytes),
        .s_min_address(s_min_address), .s_max_address(s_max_address),
        .s_allocation_handle(s_allocation_handle),
        .s_allocation_offset(s_allocation_offset),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_address(m_address), .m_total_reserved(m_total_reserved),
        .m_total_mapped(m_total_mapped),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Shadow copy of the range table, kept sorted by start address.
    bit [63:0] tbl_start [NRANGES];
    bit [63:0] tbl_size [NRANGES];
    bit        tbl_mapped [NRANGES];
    int        tbl_used = 0;
    bit [63:0] bytes_reserved = 0;
    bit [63:0] bytes_mapped = 0;
    bit [63:0] cur_guard = 64'(GUARD_RESET);
    bit [63:0] cur_limit = 64'(LIMIT_RESET);

    outcome_t pending_results[$];
    int errors = 0;
    int words_sent = 0;
    int words_checked = 0;
    int burst_left = 0;
    bit hold_req = 1'b0;

    function automatic bit [63:0] page_up(bit [63:0] v);
        return (v + PAGE - 1) & ~(PAGE - 1);
    endfunction

    function automatic bit [63:0] floor_address();
        bit [63:0] f;
        f = page_up(cur_guard);
        return (f < PAGE) ? PAGE : f;
    endfunction

    function automatic bit collides(bit [63:0] a, bit [63:0] s);
        for (int i = 0; i < tbl_used; i++) begin
            if (tbl_start[i] >= a + s)
                return 1'b0;
            if (a < tbl_start[i] + tbl_size[i])
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit first_gap(bit [63:0] lo, bit [63:0] hi, bit [63:0] s,
                                     output bit [63:0] where);
        bit [63:0] cand;
        bit [63:0] en;
        cand = page_up(lo);
        where = 0;
        if (hi > SPACE_END)
            hi = SPACE_END;
        for (int i = 0; i < tbl_used; i++) begin
            en = tbl_start[i] + tbl_size[i];
            if (en > cand) begin
                if (cand + s <= tbl_start[i] && cand + s <= hi) begin
                    where = cand;
                    return 1'b1;
                end
                cand = en;
                if (cand >= hi)
                    return 1'b0;
            end
        end
        if (cand + s <= hi) begin
            where = cand;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void drop_range(int i);
        if (tbl_mapped[i])
            bytes_mapped -= tbl_size[i];
        else
            bytes_reserved -= tbl_size[i];
        for (int k = i; k + 1 < tbl_used; k++) begin
            tbl_start[k] = tbl_start[k + 1];
            tbl_size[k] = tbl_size[k + 1];
            tbl_mapped[k] = tbl_mapped[k + 1];
        end
        tbl_used--;
    endfunction

    function automatic logic [STATUS_W-1:0] place_range(bit mapped, request_t rq,
                                                        output bit [63:0] addr);
        bit [63:0] fl;
        bit [63:0] a;
        bit [63:0] lo;
        bit [63:0] hi;
        bit [63:0] sz;
        int pos;
        addr = 0;
        fl = floor_address();
        if (rq.size == 0 || (mapped && rq.handle == 0))
            return ST_INVALID;
        if (tbl_used >= NRANGES)
            return ST_NO_MEMORY;
        sz = page_up(64'(rq.size));
        lo = (mapped && rq.min_addr != 0) ? 64'(rq.min_addr) : fl;
        hi = (mapped && rq.max_addr != 0) ? 64'(rq.max_addr) : cur_limit;
        if (rq.base != 0) begin
            a = 64'(rq.base) & ~(PAGE - 1);
            if (a < lo)
                a = page_up(lo);
            if (a + sz > SPACE_END)
                return ST_INVALID;
            if (collides(a, sz))
                return ST_CONFLICT;
        end else begin
            if (lo < fl)
                lo = fl;
            if (!first_gap(lo, hi, sz, a))
                return ST_NO_MEMORY;
        end
        pos = 0;
        while (pos < tbl_used && tbl_start[pos] <= a)
            pos++;
        for (int k = tbl_used; k > pos; k--) begin
            tbl_start[k] = tbl_start[k - 1];
            tbl_size[k] = tbl_size[k - 1];
            tbl_mapped[k] = tbl_mapped[k - 1];
        end
        tbl_start[pos] = a;
        tbl_size[pos] = sz;
        tbl_mapped[pos] = mapped;
        tbl_used++;
        if (mapped)
            bytes_mapped += sz;
        else
            bytes_reserved += sz;
        addr = a;
        return ST_OK;
    endfunction

    function automatic logic [STATUS_W-1:0] release_ranges(request_t rq);
        bit [63:0] b;
        bit [63:0] sz;
        bit found;
        int i;
        b = 64'(rq.base);
        found = 1'b0;
        i = 0;
        if (b == 0)
            return ST_INVALID;
        if (rq.size == 0) begin
            for (int k = 0; k < tbl_used; k++) begin
                if (tbl_start[k] == b) begin
                    drop_range(k);
                    return ST_OK;
                end
            end
            return ST_NOT_FOUND;
        end
        sz = page_up(64'(rq.size));
        while (i < tbl_used) begin
            if (tbl_start[i] >= b + sz)
                break;
            if (b < tbl_start[i] + tbl_size[i]) begin
                drop_range(i);
                found = 1'b1;
            end else begin
                i++;
            end
        end
        return found ? ST_OK : ST_NOT_FOUND;
    endfunction

    function automatic outcome_t predict_outcome(request_t rq);
        outcome_t r;
        bit [63:0] addr;
        addr = 0;
        case (rq.op)
            OP_RESERVE: r.status = place_range(1'b0, rq, addr);
            OP_MAP:     r.status = place_range(1'b1, rq, addr);
            OP_FREE:    r.status = release_ranges(rq);
            default:    r.status = ST_INVALID;
        endcase
        r.address = addr[ADDRESS_W-1:0];
        r.reserved = bytes_reserved[TOTAL_W-1:0];
        r.mapped = bytes_mapped[TOTAL_W-1:0];
        return r;
    endfunction

    // Result checker.
    always @(posedge aclk) begin
        outcome_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result word with no request outstanding");
                errors++;
            end else begin
                e = pending_results.pop_front();
                words_checked++;
                if (m_status !== e.status) begin
                    $error("status: expected %0d, got %0d", e.status, m_status);
                    errors++;
                end
                if (m_address !== e.address) begin
                    $error("address: expected %h, got %h", e.address, m_address);
                    errors++;
                end
                if (m_total_reserved !== e.reserved) begin
                    $error("total_reserved: expected %h, got %h",
                           e.reserved, m_total_reserved);
                    errors++;
                end
                if (m_total_mapped !== e.mapped) begin
                    $error("total_mapped: expected %h, got %h",
                           e.mapped, m_total_mapped);
                    errors++;
                end
            end
        end
    end

    // Receiver stall pattern, with a long hold-off on request.
    int hold_cnt = 0;
    int mode = 0;
    int mode_cnt = 0;
    int rx_cyc = 0;
    always @(negedge aclk) begin
        rx_cyc++;
        if (hold_req) begin
            hold_cnt = HOLD_LEN;
            hold_req = 1'b0;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_ready <= 1'b0;
        end else begin
            if (mode_cnt == 0) begin
                mode = $urandom_range(0, 3);
                mode_cnt = $urandom_range(20, 200);
            end
            mode_cnt--;
            case (mode)
                0: m_ready <= 1'b1;
                1: m_ready <= 1'($urandom_range(0, 1));
                2: m_ready <= ($urandom_range(0, 4) == 0);
                default: m_ready <= (rx_cyc % 3 != 0);
            endcase
        end
    end

    // Watchdog on cycles without any handshake.
    int idle_cycles = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic bit [63:0] rand_bits(int w);
        bit [63:0] v;
        v = {$urandom, $urandom};
        return v & ((64'd1 << w) - 1);
    endfunction

    function automatic request_t mk(logic [OP_W-1:0] op, bit [63:0] base,
                                    bit [63:0] size, bit [63:0] mn, bit [63:0] mx,
                                    bit [63:0] handle, bit [63:0] offset);
        request_t rq;
        rq.op = op;
        rq.base = base[BASE_W-1:0];
        rq.size = size[SIZE_W-1:0];
        rq.min_addr = mn[BOUND_W-1:0];
        rq.max_addr = mx[BOUND_W-1:0];
        rq.handle = handle[HANDLE_W-1:0];
        rq.offset = offset[OFFSET_W-1:0];
        return rq;
    endfunction

    task automatic send_word(request_t rq);
        @(negedge aclk);
        s_valid <= 1'b1;
        s_op <= rq.op;
        s_base_address <= rq.base;
        s_size_bytes <= rq.size;
        s_min_address <= rq.min_addr;
        s_max_address <= rq.max_addr;
        s_allocation_handle <= rq.handle;
        s_allocation_offset <= rq.offset;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(predict_outcome(rq));
        words_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat ($urandom_range(0, 8)) @(negedge aclk);
            burst_left = $urandom_range(1, 40);
        end
    endtask

    task automatic quiesce();
        @(negedge aclk);
        s_valid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, bit [63:0] value);
        quiesce();
        repeat (QUIET) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[CFG_DATA_W-1:0];
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_GUARD_BASE)
            cur_guard = value & ((64'd1 << CFG_DATA_W) - 1);
        else if (idx == CFG_SPACE_LIMIT)
            cur_limit = value & ((64'd1 << CFG_DATA_W) - 1);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic bit [63:0] near_address(bit [63:0] anchor);
        bit [63:0] a;
        a = anchor + 64'($urandom_range(0, 1023)) * PAGE;
        if ($urandom_range(0, 3) == 0)
            a += 64'($urandom_range(0, 4095));
        return a & ((64'd1 << BASE_W) - 1);
    endfunction

    function automatic request_t random_request();
        request_t rq;
        bit [63:0] anchor;
        int r;
        int k;
        anchor = floor_address();
        if (anchor >= SPACE_END - 64'h400_0000)
            anchor = 64'h10000;
        rq = mk(OP_RESERVE, 0, 0, 0, 0, 64'($urandom), rand_bits(OFFSET_W));
        r = $urandom_range(0, 99);
        rq.op = (r < 35) ? OP_RESERVE : (r < 60) ? OP_MAP : (r < 98) ? OP_FREE : OP_UNKNOWN;
        k = $urandom_range(0, 9);
        rq.base = (k < 4) ? '0 :
                  (k < 9) ? BASE_W'(near_address(anchor)) : BASE_W'(rand_bits(BASE_W));
        k = $urandom_range(0, 9);
        if (k < 6)
            rq.size = SIZE_W'(64'($urandom_range(1, 16)) * PAGE
                              - 64'($urandom_range(0, 4095)));
        else if (k < 8)
            rq.size = SIZE_W'($urandom_range(1, 65536));
        else if (k == 8)
            rq.size = SIZE_W'(rand_bits(SIZE_W));
        else
            rq.size = '0;
        if (rq.op == OP_FREE && tbl_used > 0 && $urandom_range(0, 9) < 6) begin
            rq.base = BASE_W'(tbl_start[$urandom_range(0, tbl_used - 1)]);
            rq.size = $urandom_range(0, 1) ? '0 : SIZE_W'($urandom_range(1, 40000));
        end
        k = $urandom_range(0, 9);
        rq.min_addr = (k < 6) ? '0 :
                      (k < 9) ? BOUND_W'(near_address(anchor)) : BOUND_W'(rand_bits(BOUND_W));
        k = $urandom_range(0, 9);
        rq.max_addr = (k < 6) ? '0 :
                      (k < 9) ? BOUND_W'(anchor + 64'($urandom_range(1, 2048)) * PAGE) :
                      BOUND_W'(rand_bits(BOUND_W));
        if ($urandom_range(0, 19) == 0)
            rq.handle = '0;
        return rq;
    endfunction

    task automatic test_directed();
        request_t list[$];
        list.push_back(mk(OP_RESERVE, 0, 1, 0, 0, 0, 0));
        list.push_back(mk(OP_RESERVE, 64'h10000, 4096, 0, 0, 0, 0));
        list.push_back(mk(OP_RESERVE, 64'h20001, 64'h1001, 0, 0, 0, 0));
        list.push_back(mk(OP_RESERVE, 0, 0, 0, 0, 0, 0));
        list.push_back(mk(OP_MAP, 0, 4096, 0, 0, 0, 0));
        list.push_back(mk(OP_MAP, 0, 64'h4000, 64'h30000, 64'h40000, 1, 64'hFFFF_FFFF_FFFF));
        list.push_back(mk(OP_MAP, 0, 64'h2000, 1, 64'h12000, 7, 0));
        list.push_back(mk(OP_MAP, 7, 1, 64'h50001, 0, 64'hFFFF_FFFF, 5));
        list.push_back(mk(OP_RESERVE, 64'hFFFF_FFFF_FFFF, 4096, 0, 0, 0, 0));
        list.push_back(mk(OP_RESERVE, 64'hFFFF_FFFF_E000, 64'h3000, 0, 0, 0, 0));
        list.push_back(mk(OP_RESERVE, 0, SPACE_END, 0, 0, 0, 0));
        list.push_back(mk(OP_RESERVE, 0, 64'h1_FFFF_FFFF_FFFF, 0, 0, 0, 0));
        list.push_back(mk(OP_FREE, 0, 4096, 0, 0, 0, 0));
        list.push_back(mk(OP_FREE, 64'h20000, 0, 0, 0, 0, 0));
        list.push_back(mk(OP_FREE, 64'h20000, 0, 0, 0, 0, 0));
        list.push_back(mk(OP_FREE, 64'h10000, 64'h50000, 0, 0, 0, 0));
        list.push_back(mk(OP_FREE, 1, 1, 0, 0, 0, 0));
        list.push_back(mk(OP_UNKNOWN, 64'hFFFF_FFFF_FFFF, 64'h1_FFFF_FFFF_FFFF,
                          64'h1_FFFF_FFFF_FFFF, 64'h1_FFFF_FFFF_FFFF,
                          64'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF));
        list.push_back(mk(OP_MAP, 0, 4096, SPACE_END, 64'h1_FFFF_FFFF_FFFF, 3, 0));
        list.push_back(mk(OP_FREE, 64'hFFFF_FFFF_F000, 64'h1_FFFF_FFFF_FFFF, 0, 0, 0, 0));
        list.push_back(mk(OP_MAP, 0, 4096, 0, 0, 64'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF));
        foreach (list[i])
            send_word(list[i]);
        quiesce();
    endtask

    task automatic test_table_full();
        for (int i = 0; i <= NRANGES; i++)
            send_word(mk(OP_RESERVE, 0, 4096, 0, 0, 0, 0));
        send_word(mk(OP_MAP, 64'h8000_0000, 4096, 0, 0, 9, 0));
        send_word(mk(OP_RESERVE, 0, 0, 0, 0, 0, 0));
        send_word(mk(OP_FREE, 1, 64'h1_FFFF_FFFF_FFFF, 0, 0, 0, 0));
        quiesce();
    endtask

    task automatic test_backpressure();
        quiesce();
        hold_req = 1'b1;
        for (int i = 0; i < 30; i++)
            send_word(random_request());
        quiesce();
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++) begin
            send_word(random_request());
            if ($urandom_range(0, 199) == 0)
                quiesce();
        end
        send_word(mk(OP_FREE, 1, 64'h1_FFFF_FFFF_FFFF, 0, 0, 0, 0));
        quiesce();
    endtask

    task automatic test_settings();
        write_reg(CFG_GUARD_BASE, 0);
        write_reg(CFG_SPACE_LIMIT, SPACE_END);
        test_random(300);
        write_reg(CFG_GUARD_BASE, SPACE_END);
        test_random(150);
        write_reg(CFG_GUARD_BASE, 64'h12345);
        write_reg(CFG_SPACE_LIMIT, 64'h40_0000);
        test_random(300);
        write_reg(CFG_SPACE_LIMIT, 0);
        test_random(150);
        write_reg(CFG_SPACE_LIMIT, 64'h1_FFFF_FFFF_FFFF);
        write_reg(CFG_NO_REG, 64'h1234);
        write_reg(CFG_GUARD_BASE, 64'(GUARD_RESET));
        test_random(300);
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_table_full();
        test_random(700);
        test_backpressure();
        test_settings();
        quiesce();
        repeat (QUIET) @(posedge aclk);
        $display("Run covered %0d request words and %0d checked results, with",
                 words_sent, words_checked);
        $display("reserve, map, free and invalid ops over six register settings.");
        if (errors == 0 && pending_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
